@@ sv/abcc_pkg.sv @@
// Package for the "abc" occurrence counter: symbol codes, field widths and
// item opcodes. No dependencies; every other file of the block imports it.
package abcc_pkg;

    // Field widths of the input and result items.
    localparam int OP_W       = 2;
    localparam int POS_W      = 12;
    localparam int SYM_W      = 8;
    localparam int COUNT_W    = 11;

    // Default buffer capacity in characters.
    localparam int DEFAULT_MAX_LEN = 4096;

    // Characters of the pattern.
    localparam logic [SYM_W-1:0] SYM_A = 8'h61;
    localparam logic [SYM_W-1:0] SYM_B = 8'h62;
    localparam logic [SYM_W-1:0] SYM_C = 8'h63;

    // Item opcodes; the fourth code is unused and leaves the state alone.
    typedef enum logic [OP_W-1:0] {
        OP_RESTART = 2'd0,
        OP_APPEND  = 2'd1,
        OP_REPLACE = 2'd2
    } op_t;

endpackage

@@ sv/abcc_in_if.sv @@
// Input channel of the occurrence counter: valid/ready plus one edit item.
// Depends on abcc_pkg for the field widths.
interface abcc_in_if;
    import abcc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, output op, output position, output symbol, input ready);
    modport sink   (input valid, input op, input position, input symbol, output ready);
endinterface

@@ sv/abcc_out_if.sv @@
// Result channel of the occurrence counter: valid/ready plus count and error flag.
// Depends on abcc_pkg for the field widths.
interface abcc_out_if;
    import abcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_count;
    logic               error;

    modport source (output valid, output match_count, output error, input ready);
    modport sink   (input valid, input match_count, input error, output ready);
endinterface

@@ sv/abc_occurrence_counter_with_updates.sv @@
// Top level of the "abc" occurrence counter: character memory, edit sequencer
// and result register. Depends on abcc_pkg, abcc_in_if and abcc_out_if.
//
//   channel   modport  payload                          role
//   in_ch     sink     op, position, symbol             edit items
//   out_ch    source   match_count, error               one result per item
//
// Restart, append, the unused opcode and any rejected item are answered
// directly: the result register loads at the transfer. A replace that is in
// range reads those of the five characters around the index that lie in the
// text from the single-port memory, one per cycle, then updates the count and
// writes the memory if the character changes. Reset clears the length, the
// count and the handshake state; the memory is not cleared. A new item is taken
// once the sequencer is idle and the result register is empty or being drained.
module abc_occurrence_counter_with_updates #(
    parameter int MAX_LEN = abcc_pkg::DEFAULT_MAX_LEN
) (
    input  logic       clk,
    input  logic       rst_n,
    abcc_in_if.sink    in_ch,
    abcc_out_if.source out_ch
);
    import abcc_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int PW = (LW > POS_W) ? LW : POS_W;
    localparam int SW = PW + 1;
    localparam int WIN = 5;
    localparam int IW = 3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_CALC = 4'b1000
    } state_t;

    // Control state.
    state_t             state_reg, state_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;

    // Payload state.
    logic [SW-1:0]      pos_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [IW-1:0]      pend_idx_reg;
    logic [SYM_W-1:0]   win_reg [WIN];
    logic [WIN-1:0]     ok_reg;
    logic [SYM_W-1:0]   last1_reg;
    logic [SYM_W-1:0]   last2_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_err_reg;

    // Character memory.
    logic [SYM_W-1:0]   mem [MAX_LEN];
    logic [SYM_W-1:0]   rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [SYM_W-1:0]   wr_data;

    logic               accept;
    logic               out_load;
    logic [COUNT_W-1:0] out_count_new;
    logic               out_err_new;
    logic [SW-1:0]      len_x;
    logic [SW-1:0]      pos_in_x;
    logic [SW-1:0]      sum_x;
    logic [SW-1:0]      addr_x;
    logic               ok_now;
    logic               full;
    logic               append_hit;
    logic               old_cov;
    logic               new_cov;
    logic [SYM_W-1:0]   old_sym;

    assign len_x    = SW'(len_reg);
    assign pos_in_x = SW'(in_ch.position);
    assign full     = (len_reg == LW'(MAX_LEN));

    // Handshake.
    assign in_ch.ready        = (state_reg == ST_IDLE) && (!out_valid_reg || out_ch.ready);
    assign accept             = in_ch.valid && in_ch.ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.match_count = out_count_reg;
    assign out_ch.error       = out_err_reg;

    // Window address for the current read step and whether it lies in the text.
    assign sum_x  = pos_reg + SW'(idx_reg);
    assign addr_x = sum_x - SW'(2);
    assign ok_now = (sum_x >= SW'(2)) && (sum_x < len_x + SW'(2));

    // An append completes the pattern when the two previous characters are "ab".
    assign append_hit = (len_reg >= LW'(2)) && (last2_reg == SYM_A)
                        && (last1_reg == SYM_B) && (in_ch.symbol == SYM_C);

    // Old and new occurrence covering the replaced index.
    assign old_sym = win_reg[2];

    always_comb
    begin
        old_cov = 1'b0;
        case (old_sym)
            SYM_A: old_cov = ok_reg[4] && (win_reg[3] == SYM_B) && (win_reg[4] == SYM_C);
            SYM_B: old_cov = ok_reg[1] && ok_reg[3] && (win_reg[1] == SYM_A)
                             && (win_reg[3] == SYM_C);
            SYM_C: old_cov = ok_reg[0] && (win_reg[0] == SYM_A) && (win_reg[1] == SYM_B);
            default: old_cov = 1'b0;
        endcase
        new_cov = 1'b0;
        case (sym_reg)
            SYM_A: new_cov = ok_reg[4] && (win_reg[3] == SYM_B) && (win_reg[4] == SYM_C);
            SYM_B: new_cov = ok_reg[1] && ok_reg[3] && (win_reg[1] == SYM_A)
                             && (win_reg[3] == SYM_C);
            SYM_C: new_cov = ok_reg[0] && (win_reg[0] == SYM_A) && (win_reg[1] == SYM_B);
            default: new_cov = 1'b0;
        endcase
    end

    // Sequencer, length and count updates, memory access control.
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_load       = 1'b0;
        out_count_new  = count_reg;
        out_err_new    = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = addr_x[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = len_reg[AW-1:0];
        wr_data        = in_ch.symbol;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_load = 1'b1;
                    case (in_ch.op)
                        OP_RESTART:
                        begin
                            len_next      = '0;
                            count_next    = '0;
                            out_count_new = '0;
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                out_err_new = 1'b1;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                len_next = len_reg + LW'(1);
                                if (append_hit)
                                begin
                                    count_next    = count_reg + COUNT_W'(1);
                                    out_count_new = count_reg + COUNT_W'(1);
                                end
                            end
                        end
                        OP_REPLACE:
                        begin
                            if (pos_in_x >= len_x)
                            begin
                                out_err_new = 1'b1;
                            end
                            else
                            begin
                                out_load   = 1'b0;
                                idx_next   = '0;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            out_err_new = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rd_en     = ok_now;
                pend_next = ok_now;
                idx_next  = idx_reg + IW'(1);
                if (idx_reg == IW'(WIN - 1))
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                out_load = 1'b1;
                if (old_sym != sym_reg)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = pos_reg[AW-1:0];
                    wr_data       = sym_reg;
                    count_next    = count_reg - COUNT_W'(old_cov) + COUNT_W'(new_cov);
                    out_count_new = count_next;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item capture, read window, tail characters and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg <= pos_in_x;
            sym_reg <= in_ch.symbol;
        end
        if (state_reg == ST_READ)
        begin
            pend_idx_reg     <= idx_reg;
            ok_reg[idx_reg]  <= ok_now;
        end
        if (pend_reg)
        begin
            win_reg[pend_idx_reg] <= rd_data_reg;
        end
        // The last two characters follow appends and replaces at the tail.
        if (accept && (in_ch.op == OP_APPEND) && !full)
        begin
            last2_reg <= last1_reg;
            last1_reg <= in_ch.symbol;
        end
        else if (state_reg == ST_CALC)
        begin
            if (pos_reg == len_x - SW'(1))
            begin
                last1_reg <= sym_reg;
            end
            if (pos_reg == len_x - SW'(2))
            begin
                last2_reg <= sym_reg;
            end
        end
        if (out_load)
        begin
            out_count_reg <= out_count_new;
            out_err_reg   <= out_err_new;
        end
    end

    // Single-port character memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ tb/abcc_checker.sv @@
// Scoreboard for the "abc" occurrence counter: watches both channels, predicts
// each result from the edit stream and compares it. Depends on abcc_pkg and on
// the abcc_in_if and abcc_out_if interfaces.
`timescale 1ns / 1ps

module abcc_checker #(
    parameter int MAX_LEN = abcc_pkg::DEFAULT_MAX_LEN
) (
    input  logic clk,
    input  logic rst_n,
    abcc_in_if   in_ch,
    abcc_out_if  out_ch,
    output int   mismatch_count,
    output int   results_owed
);
    import abcc_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               error;
    } result_t;

    // Shadow copy of the text buffer, its length and the running count.
    logic [SYM_W-1:0]   text_copy [MAX_LEN];
    int unsigned        copy_len;
    logic [COUNT_W-1:0] tally;
    result_t            owed_q [$];

    // True if the one "abc" occurrence that could include index k is present.
    function automatic bit match_through(int unsigned k);
        logic [SYM_W-1:0] ch;
        ch = text_copy[k];
        if (ch == SYM_A)
            return (k + 2 < copy_len) && text_copy[k+1] == SYM_B && text_copy[k+2] == SYM_C;
        if (ch == SYM_B)
            return (k >= 1) && (k + 1 < copy_len) &&
                   text_copy[k-1] == SYM_A && text_copy[k+1] == SYM_C;
        if (ch == SYM_C)
            return (k >= 2) && text_copy[k-2] == SYM_A && text_copy[k-1] == SYM_B;
        return 1'b0;
    endfunction

    // Applies one edit to the shadow state and returns the result it must produce.
    function automatic result_t apply_edit(logic [OP_W-1:0] code, logic [POS_W-1:0] pos,
                                           logic [SYM_W-1:0] sym);
        result_t res;
        res.error = 1'b0;
        case (code)
            OP_RESTART:
            begin
                copy_len = 0;
                tally    = '0;
            end
            OP_APPEND:
            begin
                if (copy_len >= MAX_LEN)
                    res.error = 1'b1;
                else
                begin
                    text_copy[copy_len] = sym;
                    copy_len++;
                    if (copy_len >= 3 && text_copy[copy_len-3] == SYM_A &&
                        text_copy[copy_len-2] == SYM_B && sym == SYM_C)
                        tally++;
                end
            end
            OP_REPLACE:
            begin
                if (pos >= copy_len || pos >= MAX_LEN)
                    res.error = 1'b1;
                else if (text_copy[pos] != sym)
                begin
                    // Drop the occurrence through the old character, then
                    // count the one through the new character.
                    if (match_through(pos))
                        tally--;
                    text_copy[pos] = sym;
                    if (match_through(pos))
                        tally++;
                end
            end
            default:
            begin
            end
        endcase
        res.match_count = tally;
        return res;
    endfunction

    // Results are checked before edits are queued, so a result in the same
    // cycle as an edit transfer is matched against the older expectation.
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            copy_len       = 0;
            tally          = '0;
            owed_q.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.match_count = out_ch.match_count;
                got.error       = out_ch.error;
                if (owed_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result transfer: count %0d error %0b",
                             $time, got.match_count, got.error);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (got.match_count !== want.match_count)
                    begin
                        mismatch_count++;
                        $display("%0t: match_count mismatch: expected %0d, actual %0d",
                                 $time, want.match_count, got.match_count);
                    end
                    if (got.error !== want.error)
                    begin
                        mismatch_count++;
                        $display("%0t: error flag mismatch: expected %0b, actual %0b",
                                 $time, want.error, got.error);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                owed_q = {owed_q, apply_edit(in_ch.op, in_ch.position, in_ch.symbol)};
            results_owed = owed_q.size();
        end
    end

endmodule

@@ tb/abc_occurrence_counter_with_updates_tb.sv @@
// Top of the occurrence counter testbench: clock, reset and edit stimulus with
// handshake pressure on both channels. Depends on abcc_pkg, the two channel
// interfaces, the counter RTL and abcc_checker.
`timescale 1ns / 1ps

module abc_occurrence_counter_with_updates_tb;
    import abcc_pkg::*;

    localparam int                TEXT_CAP      = DEFAULT_MAX_LEN;
    localparam logic [OP_W-1:0]   OP_SPARE      = 2'd3;
    localparam int                POS_MAX       = 2 ** POS_W - 1;
    localparam int                CYCLE_LIMIT   = 600000;
    localparam int                DRAIN_CYCLES  = 20;
    localparam int                PHASE_ITEMS   = 300;
    localparam int                RESTART_LEN   = 48;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cycle_count;
    int   mismatch_count;
    int   results_owed;
    int   text_len;
    int   abc_phase;

    abcc_in_if  in_ch ();
    abcc_out_if out_ch ();

    abc_occurrence_counter_with_updates #(
        .MAX_LEN (TEXT_CAP)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    abcc_checker #(
        .MAX_LEN (TEXT_CAP)
    ) scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // 50 MHz clock.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result-side back-pressure, redrawn every cycle.
    always @(negedge clk)
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);

    // Watchdog on the whole run.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Presents one edit and holds it until the transfer happens.
    task automatic send_item(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos,
                             input logic [SYM_W-1:0] sym);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.op       = code;
        in_ch.position = pos;
        in_ch.symbol   = sym;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // Track the length only to steer positions of later edits.
        if (code == OP_RESTART)
            text_len = 0;
        else if (code == OP_APPEND && text_len < TEXT_CAP)
            text_len++;
    endtask

    function automatic logic [SYM_W-1:0] abc_symbol(int idx);
        case (idx % 3)
            0:       return SYM_A;
            1:       return SYM_B;
            default: return SYM_C;
        endcase
    endfunction

    // Mostly pattern letters, sometimes any byte.
    function automatic logic [SYM_W-1:0] edit_symbol();
        if ($urandom_range(9) < 7)
            return abc_symbol($urandom_range(2));
        return 8'($urandom_range(255));
    endfunction

    // Hand-picked edits around a short text: matches made and broken at each
    // letter of the pattern, no-op replaces, rejected edits and the spare code.
    task automatic run_directed();
        send_item(OP_RESTART, '0, '0);
        for (int i = 0; i < 6; i++)
            send_item(OP_APPEND, '0, abc_symbol(i));
        send_item(OP_REPLACE, 12'd1, SYM_B);
        send_item(OP_REPLACE, 12'd1, 8'hFF);
        send_item(OP_REPLACE, 12'd1, SYM_B);
        send_item(OP_REPLACE, 12'd5, 8'h00);
        send_item(OP_REPLACE, 12'd5, SYM_C);
        send_item(OP_REPLACE, 12'd3, SYM_C);
        send_item(OP_REPLACE, 12'd3, SYM_A);
        send_item(OP_REPLACE, 12'd6, SYM_A);
        send_item(OP_REPLACE, 12'(POS_MAX), 8'hFF);
        send_item(OP_SPARE, 12'(POS_MAX), 8'hFF);
        send_item(OP_APPEND, 12'(POS_MAX), 8'hFF);
        send_item(OP_APPEND, '0, 8'h00);
        send_item(OP_RESTART, 12'(POS_MAX), 8'hFF);
        send_item(OP_REPLACE, '0, SYM_A);
    endtask

    // One random edit. Appends mostly continue an "abc" run so that matches
    // keep forming; replaces mostly hit the live text.
    task automatic random_item();
        int                  pick;
        logic [SYM_W-1:0]    sym;
        pick = $urandom_range(99);
        if (pick < 3 || (text_len >= RESTART_LEN && $urandom_range(3) == 0))
            send_item(OP_RESTART, 12'($urandom_range(POS_MAX)), 8'($urandom_range(255)));
        else if (pick < 50)
        begin
            if ($urandom_range(9) < 6)
            begin
                sym = abc_symbol(abc_phase);
                abc_phase++;
            end
            else
                sym = edit_symbol();
            send_item(OP_APPEND, 12'($urandom_range(POS_MAX)), sym);
        end
        else if (pick < 85 && text_len > 0)
            send_item(OP_REPLACE, 12'($urandom_range(text_len - 1)), edit_symbol());
        else if (pick < 95)
            send_item(OP_REPLACE, 12'($urandom_range(POS_MAX, text_len)), edit_symbol());
        else
            send_item(OP_SPARE, 12'($urandom_range(POS_MAX)), 8'($urandom_range(255)));
    endtask

    initial
    begin
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_RESTART;
        in_ch.position = '0;
        in_ch.symbol   = '0;
        out_ch.ready   = 1'b0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        text_len       = 0;
        abc_phase      = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        // Random phases: free flow, idle sender, stalling receiver, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                default:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            repeat (PHASE_ITEMS) random_item();
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
